[src/mcd_pkg.sv]
// Shared constants, codes and types of the depth-first maze carver.
`default_nettype none
package mcd_pkg;

    // Grid and stack geometry
    localparam int GRID_SIZE   = 21;
    localparam int STACK_DEPTH = 121;

    // Coordinate width of the row and column words
    localparam int COORD_W = 5;

    // Wall memory: one bit per cell, row-major
    localparam int MAP_N = GRID_SIZE * GRID_SIZE;
    localparam int MA_W  = $clog2(MAP_N);

    // Stack index and stack depth counter widths
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SD_W = $clog2(STACK_DEPTH + 1);

    // Highest legal row or column
    localparam logic [COORD_W-1:0] GRID_LAST = COORD_W'(GRID_SIZE - 1);

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Step directions
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // Result of the neighbor unit
    typedef struct packed {
        logic               in_grid;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [MA_W-1:0]    addr;
    } nbr_t;

endpackage
`default_nettype wire

[src/mcd_nbr.sv]
// Neighbor unit: offsets a cell by 0, 1 or 2 in one direction, checks bounds, forms the address.
`default_nettype none
module mcd_nbr
(
    input  wire logic [mcd_pkg::COORD_W-1:0] row,
    input  wire logic [mcd_pkg::COORD_W-1:0] col,
    input  wire mcd_pkg::dir_t               dir,
    input  wire logic [1:0]                  span,
    output mcd_pkg::nbr_t                    nbr
);

    logic [mcd_pkg::COORD_W:0]   row_w;
    logic [mcd_pkg::COORD_W:0]   col_w;
    logic [mcd_pkg::COORD_W:0]   dist_w;
    logic [mcd_pkg::COORD_W:0]   sum_r;
    logic [mcd_pkg::COORD_W:0]   sum_c;
    logic [mcd_pkg::COORD_W:0]   grid_w;
    logic [mcd_pkg::COORD_W-1:0] row_o;
    logic [mcd_pkg::COORD_W-1:0] col_o;
    logic                        ok;

    assign row_w  = {1'b0, row};
    assign col_w  = {1'b0, col};
    assign dist_w = (mcd_pkg::COORD_W + 1)'(span);
    assign sum_r  = row_w + dist_w;
    assign sum_c  = col_w + dist_w;
    assign grid_w = (mcd_pkg::COORD_W + 1)'(mcd_pkg::GRID_SIZE);

    // Step the coordinate and check the grid edge
    always_comb
    begin
        row_o = row;
        col_o = col;
        ok    = 1'b1;
        case (dir)
            mcd_pkg::DIR_UP:
            begin
                ok    = (row_w >= dist_w);
                row_o = row - mcd_pkg::COORD_W'(span);
            end
            mcd_pkg::DIR_DOWN:
            begin
                ok    = (sum_r < grid_w);
                row_o = sum_r[mcd_pkg::COORD_W-1:0];
            end
            mcd_pkg::DIR_LEFT:
            begin
                ok    = (col_w >= dist_w);
                col_o = col - mcd_pkg::COORD_W'(span);
            end
            mcd_pkg::DIR_RIGHT:
            begin
                ok    = (sum_c < grid_w);
                col_o = sum_c[mcd_pkg::COORD_W-1:0];
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Row-major address: row times grid size plus column
    assign nbr.in_grid = ok;
    assign nbr.row     = row_o;
    assign nbr.col     = col_o;
    assign nbr.addr    = mcd_pkg::MA_W'(row_o) * mcd_pkg::MA_W'(mcd_pkg::GRID_SIZE)
                       + mcd_pkg::MA_W'(col_o);

endmodule
`default_nettype wire

[src/maze_carver_dfs.sv]
// Top level of the depth-first maze carver: sequencer, wall memory, path stack, output word.
//
// Depth-first (recursive backtracker) maze carver on a 21 x 21 grid with one wall bit per
// cell and an explicit path stack. A start word walls the whole grid with a sweep over
// all GRID_SIZE*GRID_SIZE cells (441), then carves and reports the start cell. A step
// word probes the cell two away in the given direction through the single neighbor
// unit and the registered read of the wall memory, each probe passing through S_PROBE
// and then S_TEST; a successful carve returns two words (the wall cell between, then
// the target). A blocked probe falls into a scan of all four directions, and a pop
// reloads the new top from the stack memory through S_POP and S_RELOAD. A pop that
// empties the stack returns one finished word. The input side is ready only while the
// sequencer is idle; the output word register lets the next word be taken while a
// result still waits, and the sequencer holds when it has a result to emit and the
// output word is still occupied.
`default_nettype none
module maze_carver_dfs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [mcd_pkg::COORD_W-1:0] start_row,
    input  wire logic [mcd_pkg::COORD_W-1:0] start_col,
    input  wire logic [1:0]                  direction,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mcd_pkg::COORD_W-1:0]      cell_row,
    output logic [mcd_pkg::COORD_W-1:0]      cell_col,
    output logic                             carved,
    output logic                             finished,
    output logic                             last_of_run
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_START,
        S_PROBE,
        S_TEST,
        S_CARVE_MID,
        S_CARVE_TGT,
        S_POP,
        S_FINISH,
        S_RELOAD
    } state_t;

    localparam int CW = mcd_pkg::COORD_W;

    // Sequencer state
    state_t                     state_reg,     state_next;
    mcd_pkg::dir_t              dir_reg,       dir_next;
    logic                       first_reg,     first_next;
    logic                       in_grid_reg,   in_grid_next;
    logic [CW-1:0]              srow_reg,      srow_next;
    logic [CW-1:0]              scol_reg,      scol_next;
    logic [CW-1:0]              top_row_reg,   top_row_next;
    logic [CW-1:0]              top_col_reg,   top_col_next;
    logic [mcd_pkg::SD_W-1:0]   depth_reg,     depth_next;
    logic [mcd_pkg::MA_W-1:0]   clr_cnt_reg,   clr_cnt_next;

    // Output word
    logic                       out_valid_reg, out_valid_next;
    logic [CW-1:0]              out_row_reg,   out_row_next;
    logic [CW-1:0]              out_col_reg,   out_col_next;
    logic                       carved_reg,    carved_next;
    logic                       finished_reg,  finished_next;
    logic                       last_reg,      last_next;

    // Memories
    logic                       wall_mem [mcd_pkg::MAP_N];
    logic [2*CW-1:0]            stack_mem [mcd_pkg::STACK_DEPTH];
    logic                       map_q;
    logic [2*CW-1:0]            stk_q;

    logic                       map_we;
    logic [mcd_pkg::MA_W-1:0]   map_wa;
    logic                       map_wd;
    logic                       stk_we;
    logic [mcd_pkg::SA_W-1:0]   stk_wa;
    logic [2*CW-1:0]            stk_wd;
    logic [mcd_pkg::SD_W-1:0]   depth_m2;
    logic [mcd_pkg::SA_W-1:0]   stk_ra;

    // Neighbor unit operands
    logic [CW-1:0]              u_row;
    logic [CW-1:0]              u_col;
    mcd_pkg::dir_t              u_dir;
    logic [1:0]                 u_dist;
    mcd_pkg::nbr_t              nbr;

    logic                       in_acc;
    logic                       out_free;
    logic                       hit;
    logic                       stack_full;

    mcd_nbr u_nbr
    (
        .row  (u_row),
        .col  (u_col),
        .dir  (u_dir),
        .span (u_dist),
        .nbr  (nbr)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign hit        = in_grid_reg && map_q;
    assign stack_full = (depth_reg == mcd_pkg::SD_W'(mcd_pkg::STACK_DEPTH));
    assign depth_m2   = depth_reg - mcd_pkg::SD_W'(2);
    assign stk_ra     = depth_m2[mcd_pkg::SA_W-1:0];

    assign out_valid   = out_valid_reg;
    assign cell_row    = out_row_reg;
    assign cell_col    = out_col_reg;
    assign carved      = carved_reg;
    assign finished    = finished_reg;
    assign last_of_run = last_reg;

    // Pick the neighbor unit operands for the current step
    always_comb
    begin
        u_row  = top_row_reg;
        u_col  = top_col_reg;
        u_dir  = dir_reg;
        u_dist = 2'd2;
        case (state_reg)
            S_START:
            begin
                u_row  = srow_reg;
                u_col  = scol_reg;
                u_dist = 2'd0;
            end
            S_CARVE_MID:
            begin
                u_dist = 2'd1;
            end
            default:
            begin
                u_dist = 2'd2;
            end
        endcase
    end

    // Sequencer next state, memory writes and output word
    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        first_next     = first_reg;
        in_grid_next   = in_grid_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        top_row_next   = top_row_reg;
        top_col_next   = top_col_reg;
        depth_next     = depth_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        carved_next    = carved_reg;
        finished_next  = finished_reg;
        last_next      = last_reg;
        map_we         = 1'b0;
        map_wa         = nbr.addr;
        map_wd         = 1'b0;
        stk_we         = 1'b0;
        stk_wa         = depth_reg[mcd_pkg::SA_W-1:0];
        stk_wd         = {nbr.row, nbr.col};

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == mcd_pkg::ACT_START)
                    begin
                        // Saturate the start cell into the grid
                        srow_next    = (start_row > mcd_pkg::GRID_LAST) ? mcd_pkg::GRID_LAST
                                                                         : start_row;
                        scol_next    = (start_col > mcd_pkg::GRID_LAST) ? mcd_pkg::GRID_LAST
                                                                         : start_col;
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                    else if (depth_reg != '0)
                    begin
                        dir_next   = mcd_pkg::dir_t'(direction);
                        first_next = 1'b1;
                        state_next = S_PROBE;
                    end
                end
            end

            S_CLEAR:
            begin
                // Sweep the grid back to walls
                map_we = 1'b1;
                map_wa = clr_cnt_reg;
                map_wd = 1'b1;
                if (clr_cnt_reg == mcd_pkg::MA_W'(mcd_pkg::MAP_N - 1))
                begin
                    state_next = S_START;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + mcd_pkg::MA_W'(1);
                end
            end

            S_START:
            begin
                if (out_free)
                begin
                    map_we         = 1'b1;
                    stk_we         = 1'b1;
                    stk_wa         = '0;
                    top_row_next   = srow_reg;
                    top_col_next   = scol_reg;
                    depth_next     = mcd_pkg::SD_W'(1);
                    out_valid_next = 1'b1;
                    out_row_next   = srow_reg;
                    out_col_next   = scol_reg;
                    carved_next    = 1'b1;
                    finished_next  = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_PROBE:
            begin
                // Wall memory read of the target is issued this cycle
                in_grid_next = nbr.in_grid;
                state_next   = S_TEST;
            end

            S_TEST:
            begin
                if (first_reg)
                begin
                    if (hit && !stack_full)
                    begin
                        state_next = S_CARVE_MID;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        dir_next   = mcd_pkg::DIR_UP;
                        state_next = S_PROBE;
                    end
                end
                else if (hit)
                begin
                    // Top cell still has a wall neighbor: drop the step
                    state_next = S_IDLE;
                end
                else if (dir_reg == mcd_pkg::DIR_RIGHT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next   = mcd_pkg::dir_t'(dir_reg + 2'd1);
                    state_next = S_PROBE;
                end
            end

            S_CARVE_MID:
            begin
                if (out_free)
                begin
                    map_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_row_next   = nbr.row;
                    out_col_next   = nbr.col;
                    carved_next    = 1'b1;
                    finished_next  = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_CARVE_TGT;
                end
            end

            S_CARVE_TGT:
            begin
                if (out_free)
                begin
                    // Carve the target and push it
                    map_we         = 1'b1;
                    stk_we         = 1'b1;
                    top_row_next   = nbr.row;
                    top_col_next   = nbr.col;
                    depth_next     = depth_reg + mcd_pkg::SD_W'(1);
                    out_valid_next = 1'b1;
                    out_row_next   = nbr.row;
                    out_col_next   = nbr.col;
                    carved_next    = 1'b1;
                    finished_next  = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_POP:
            begin
                if (depth_reg == mcd_pkg::SD_W'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    // Stack read of the new top is issued this cycle
                    depth_next = depth_reg - mcd_pkg::SD_W'(1);
                    state_next = S_RELOAD;
                end
            end

            S_RELOAD:
            begin
                top_row_next = stk_q[2*CW-1:CW];
                top_col_next = stk_q[CW-1:0];
                state_next   = S_IDLE;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    depth_next     = '0;
                    out_valid_next = 1'b1;
                    out_row_next   = '0;
                    out_col_next   = '0;
                    carved_next    = 1'b0;
                    finished_next  = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_reg       <= mcd_pkg::DIR_UP;
            first_reg     <= 1'b0;
            in_grid_reg   <= 1'b0;
            srow_reg      <= '0;
            scol_reg      <= '0;
            top_row_reg   <= '0;
            top_col_reg   <= '0;
            depth_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            carved_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            first_reg     <= first_next;
            in_grid_reg   <= in_grid_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            top_row_reg   <= top_row_next;
            top_col_reg   <= top_col_next;
            depth_reg     <= depth_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            carved_reg    <= carved_next;
            finished_reg  <= finished_next;
            last_reg      <= last_next;
        end
    end

    // Wall memory: one write port, registered read at the neighbor address
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            wall_mem[map_wa] <= map_wd;
        end
        map_q <= wall_mem[nbr.addr];
    end

    // Path stack: push at the depth, registered read of the entry under the top
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stk_q <= stack_mem[stk_ra];
    end

endmodule
`default_nettype wire
